FILE: hw/rtl/nmd_pkg.sv
// ----------------------------------------------------------------------------
// nmd_pkg
// Shared types and codes of the notify message deframer.
// ----------------------------------------------------------------------------
package nmd_pkg;

  localparam int unsigned CODE_W    = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNTER_W = 32;
  localparam int unsigned PAYLEN_W  = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERSION_TYPE = 2'd0,
    CFG_EVENT_TYPE   = 2'd1,
    CFG_COUNTER_TYPE = 2'd2,
    CFG_EXP_VERSION  = 2'd3
  } nmd_cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_COUNTER_NAME = 2'd0,
    KIND_EVENT_NAME   = 2'd1,
    KIND_PAYLOAD      = 2'd2,
    KIND_VERSION_ERR  = 2'd3
  } nmd_kind_t;

  typedef enum logic {
    TYPE_COUNTER = 1'b0,
    TYPE_EVENT   = 1'b1
  } nmd_msg_type_t;

  typedef enum logic [6:0] {
    STEP_HEADER  = 7'b0000001,
    STEP_VERSION = 7'b0000010,
    STEP_NAMELEN = 7'b0000100,
    STEP_COUNTER = 7'b0001000,
    STEP_PAYLEN  = 7'b0010000,
    STEP_NAME    = 7'b0100000,
    STEP_PAYLOAD = 7'b1000000
  } nmd_step_t;

  localparam logic [CODE_W-1:0] RST_VERSION_TYPE = 4'd0;
  localparam logic [CODE_W-1:0] RST_EVENT_TYPE   = 4'd1;
  localparam logic [CODE_W-1:0] RST_COUNTER_TYPE = 4'd2;
  localparam logic [BYTE_W-1:0] RST_EXP_VERSION  = 8'd1;

  typedef struct packed {
    logic [CODE_W-1:0] version_type_code;
    logic [CODE_W-1:0] event_type_code;
    logic [CODE_W-1:0] counter_type_code;
    logic [BYTE_W-1:0] expected_version;
  } nmd_cfg_t;

  typedef struct packed {
    nmd_kind_t            result_kind;
    logic                 has_byte;
    logic [BYTE_W-1:0]    data_byte;
    logic [COUNTER_W-1:0] counter_reading;
    logic                 message_end;
  } nmd_result_t;

endpackage

FILE: hw/rtl/notify_message_deframer_top.sv
// ----------------------------------------------------------------------------
// notify_message_deframer_top
// Byte stream deframer for version, counter and event notification messages.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per transaction (s_tdata[7:0]).
//   m_* carries one result per transaction: m_tdata holds data_byte and
//   counter_reading, m_tuser holds result_kind and has_byte, m_tlast marks
//   the final result of a message.
//   cfg_* writes one configuration register per transaction; write only
//   while the stream is idle.
// Timing:
//   One byte per cycle sustained while m_tready does not hold a pending
//   result. A byte is registered in the input register at acceptance, then
//   parsed into the output register, from which its result, if any, is
//   presented on m_*. The rate is set by the single parser stage, which
//   updates the frame state once per byte.
// Reset and stall:
//   rst clears the frame state, the halt flag, the valid flags of both
//   pipeline registers and restores the default type codes and expected
//   version. While m_tready is low with a result pending, the parser holds;
//   if the input register is empty, one more byte is still taken into it,
//   then s_tready drops.
// ----------------------------------------------------------------------------
module notify_message_deframer_top
  import nmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // [7:0] data_byte, [39:8] counter_reading
  output logic [2:0]           m_tuser,   // [1:0] result_kind, [2] has_byte
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  nmd_cfg_t          cfg;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  nmd_result_t       out_res;
  logic              out_can;
  logic              fire;
  logic              res_valid;
  nmd_result_t       res;

  assign out_can  = !out_valid || m_tready;
  assign fire     = in_valid && out_can;
  assign s_tready = !in_valid || out_can;

  nmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nmd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.counter_reading, out_res.data_byte};
  assign m_tuser  = {out_res.has_byte, out_res.result_kind};
  assign m_tlast  = out_res.message_end;

endmodule

FILE: hw/rtl/nmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// nmd_cfg_regs
// Configuration register file: type codes and the expected version byte.
// ----------------------------------------------------------------------------
module nmd_cfg_regs
  import nmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output nmd_cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.version_type_code <= RST_VERSION_TYPE;
      cfg.event_type_code   <= RST_EVENT_TYPE;
      cfg.counter_type_code <= RST_COUNTER_TYPE;
      cfg.expected_version  <= RST_EXP_VERSION;
    end else if (cfg_valid && cfg_ready) begin
      unique case (nmd_cfg_idx_t'(cfg_index))
        CFG_VERSION_TYPE: cfg.version_type_code <= cfg_data[CODE_W-1:0];
        CFG_EVENT_TYPE:   cfg.event_type_code   <= cfg_data[CODE_W-1:0];
        CFG_COUNTER_TYPE: cfg.counter_type_code <= cfg_data[CODE_W-1:0];
        CFG_EXP_VERSION:  cfg.expected_version  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/nmd_parser.sv
// ----------------------------------------------------------------------------
// nmd_parser
// Frame state machine: one byte per transaction, zero or one result.
// ----------------------------------------------------------------------------
module nmd_parser
  import nmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [BYTE_W-1:0] rx_byte,
  input  nmd_cfg_t          cfg,
  output logic              res_valid,
  output nmd_result_t       res
);

  nmd_step_t            step, step_next;
  nmd_msg_type_t        mtype, mtype_next;
  logic [BYTE_W-1:0]    name_left, name_left_next;
  logic [PAYLEN_W-1:0]  pay_left, pay_left_next;
  logic [COUNTER_W-1:0] cshift, cshift_next;
  logic [1:0]           fidx, fidx_next;
  logic                 halted, halted_next;

  logic [CODE_W-1:0]    nib;
  logic [COUNTER_W-1:0] reading;
  logic [BYTE_W-1:0]    name_dec;
  logic [PAYLEN_W-1:0]  pay_dec;

  assign nib      = rx_byte[CODE_W-1:0];
  assign reading  = (mtype == TYPE_COUNTER) ? cshift : '0;
  assign name_dec = name_left - 1'b1;
  assign pay_dec  = pay_left - 1'b1;

  always_comb begin
    step_next      = step;
    mtype_next     = mtype;
    name_left_next = name_left;
    pay_left_next  = pay_left;
    cshift_next    = cshift;
    fidx_next      = fidx;
    halted_next    = halted;
    res_valid      = 1'b0;
    res            = '0;
    if (!halted) begin
      unique case (step)
        STEP_HEADER: begin
          priority if (nib == cfg.version_type_code) begin
            step_next = STEP_VERSION;
          end else if (nib == cfg.event_type_code) begin
            mtype_next = TYPE_EVENT;
            step_next  = STEP_NAMELEN;
          end else if (nib == cfg.counter_type_code) begin
            mtype_next = TYPE_COUNTER;
            step_next  = STEP_NAMELEN;
          end else begin
          end
        end
        STEP_VERSION: begin
          step_next = STEP_HEADER;
          if (rx_byte != cfg.expected_version) begin
            halted_next     = 1'b1;
            res_valid       = 1'b1;
            res.result_kind = KIND_VERSION_ERR;
            res.message_end = 1'b1;
          end
        end
        STEP_NAMELEN: begin
          name_left_next = rx_byte;
          fidx_next      = '0;
          if (mtype == TYPE_EVENT) begin
            pay_left_next = '0;
            step_next     = STEP_PAYLEN;
          end else begin
            cshift_next = '0;
            step_next   = STEP_COUNTER;
          end
        end
        STEP_COUNTER: begin
          cshift_next = {cshift[COUNTER_W-BYTE_W-1:0], rx_byte};
          if (fidx != 2'd3) begin
            fidx_next = fidx + 1'b1;
          end else begin
            fidx_next = '0;
            if (name_left == '0) begin
              step_next           = STEP_HEADER;
              res_valid           = 1'b1;
              res.result_kind     = KIND_COUNTER_NAME;
              res.counter_reading = cshift_next;
              res.message_end     = 1'b1;
            end else begin
              step_next = STEP_NAME;
            end
          end
        end
        STEP_PAYLEN: begin
          pay_left_next = {pay_left[PAYLEN_W-BYTE_W-1:0], rx_byte};
          if (fidx == 2'd0) begin
            fidx_next = 2'd1;
          end else begin
            fidx_next = '0;
            priority if (name_left != '0) begin
              step_next = STEP_NAME;
            end else if (pay_left_next != '0) begin
              step_next = STEP_PAYLOAD;
            end else begin
              step_next       = STEP_HEADER;
              res_valid       = 1'b1;
              res.result_kind = KIND_EVENT_NAME;
              res.message_end = 1'b1;
            end
          end
        end
        STEP_NAME: begin
          name_left_next = name_dec;
          res_valid      = 1'b1;
          res.has_byte   = 1'b1;
          res.data_byte  = rx_byte;
          if (mtype == TYPE_COUNTER) begin
            res.result_kind     = KIND_COUNTER_NAME;
            res.counter_reading = reading;
            res.message_end     = (name_dec == '0);
            if (name_dec == '0) step_next = STEP_HEADER;
          end else begin
            res.result_kind = KIND_EVENT_NAME;
            if (name_dec == '0) begin
              if (pay_left == '0) begin
                res.message_end = 1'b1;
                step_next       = STEP_HEADER;
              end else begin
                step_next = STEP_PAYLOAD;
              end
            end
          end
        end
        STEP_PAYLOAD: begin
          pay_left_next   = pay_dec;
          res_valid       = 1'b1;
          res.result_kind = KIND_PAYLOAD;
          res.has_byte    = 1'b1;
          res.data_byte   = rx_byte;
          res.message_end = (pay_dec == '0);
          if (pay_dec == '0) step_next = STEP_HEADER;
        end
        default: step_next = STEP_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_HEADER;
      mtype     <= TYPE_COUNTER;
      name_left <= '0;
      pay_left  <= '0;
      cshift    <= '0;
      fidx      <= '0;
      halted    <= 1'b0;
    end else if (fire) begin
      step      <= step_next;
      mtype     <= mtype_next;
      name_left <= name_left_next;
      pay_left  <= pay_left_next;
      cshift    <= cshift_next;
      fidx      <= fidx_next;
      halted    <= halted_next;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res_valid)
    else $error("result while halted");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.result_kind == KIND_VERSION_ERR |=> halted)
    else $error("version error did not halt");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_byte |-> res.message_end && res.data_byte == '0)
    else $error("byteless result not marked as message end");

endmodule
